// File: rtl/hkvm_pkg.sv
`default_nettype none
package hkvm_pkg;
   localparam int KEY_W = 32;
   localparam int VAL_W = 63;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [0:0] CSR_BUCKET_COUNT = 1'd0;
   localparam logic [0:0] CSR_HASH_MULT    = 1'd1;

   localparam logic [31:0] HASH_ADD   = 32'd78;
   localparam logic [31:0] HASH_PRIME = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] value_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } job_type;
endpackage
`default_nettype wire

// File: rtl/hkvm_hash.sv
`default_nettype none
// Bucket index: multiply, add, fold mod 2^31-1, then restoring mod n.
module hkvm_hash #(
   parameter int BUCKETS = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [31:0]          key,
   input  wire logic [31:0]          mult,
   input  wire logic [8:0]           bucket_count,
   output logic                      done,
   output logic [$clog2(BUCKETS)-1:0] bucket
);
   import hkvm_pkg::*;
   localparam int BW = $clog2(BUCKETS);
   localparam int NW = BW + 1;
   localparam int CW = $clog2(32);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_FOLD = 2'd2;
   localparam logic [1:0] S_DIV  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [31:0]   prod_ff, prod_in;
   logic [31:0]   h_ff, h_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] div_ff, div_in;
   logic          done_ff, done_in;
   logic [NW-1:0] n_sat;
   logic [NW:0]   trial;
   logic [31:0]   h_fold;

   always_comb begin
      if (bucket_count == 9'd0) n_sat = NW'(1);
      else if ({23'd0, bucket_count} > 32'(BUCKETS)) n_sat = NW'(BUCKETS);
      else n_sat = NW'(bucket_count);
   end

   assign trial = {rem_ff, h_ff[31]};
   // 2^31 == 1 mod 2^31-1: add the top bit back into the low 31 bits
   assign h_fold = {1'b0, h_ff[30:0]} + {31'd0, h_ff[31]};

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      h_in     = h_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               prod_in  = mult * key;
               div_in   = n_sat;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            h_in     = prod_ff + HASH_ADD;
            state_in = S_FOLD;
         end
         S_FOLD: begin
            if (h_fold >= HASH_PRIME) h_in = h_fold - HASH_PRIME;
            else h_in = h_fold;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (trial >= {1'b0, div_ff}) rem_in = NW'(trial - {1'b0, div_ff});
            else rem_in = NW'(trial);
            h_in   = {h_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(31)) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      h_ff    <= h_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      div_ff  <= div_in;
   end

   assign done   = done_ff;
   assign bucket = BW'(rem_ff);
endmodule
`default_nettype wire

// File: rtl/hkvm_table.sv
`default_nettype none
// Bucket store: one row per bucket, WAYS slots per row. Valid bits in a
// separate row memory cleared by a sweep after reset.
module hkvm_table #(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [$clog2(BUCKETS)-1:0] bucket,
   input  wire hkvm_pkg::job_type          job,
   output logic                            busy,
   output logic                            done,
   output hkvm_pkg::rsp_type               rsp
);
   import hkvm_pkg::*;
   localparam int BW = $clog2(BUCKETS);
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;

   logic [WAYS-1:0]        vmem [BUCKETS];
   logic [WAYS*KEY_W-1:0]  kmem [BUCKETS];
   logic [WAYS*VAL_W-1:0]  dmem [BUCKETS];
   logic [WAYS-1:0]        vrd_ff;
   logic [WAYS*KEY_W-1:0]  krd_ff;
   logic [WAYS*VAL_W-1:0]  drd_ff;

   logic [1:0]    state_ff, state_in;
   logic [BW:0]   clr_ff, clr_in;
   logic [BW-1:0] row_ff;
   job_type       job_ff;
   logic          done_ff;
   rsp_type       rsp_ff, rsp_in;

   logic          hit, has_free;
   logic [WW-1:0] hit_w, free_w;
   logic          v_we, kd_we;
   logic [BW-1:0] v_addr;
   logic [WAYS-1:0] v_wdata;
   logic [WAYS*KEY_W-1:0] k_wdata;
   logic [WAYS*VAL_W-1:0] d_wdata;

   always_comb begin
      hit = 1'b0; hit_w = '0; has_free = 1'b0; free_w = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (vrd_ff[w] && krd_ff[w*KEY_W +: KEY_W] == job_ff.key) begin
            hit = 1'b1; hit_w = WW'(w);
         end
         if (!vrd_ff[w]) begin
            has_free = 1'b1; free_w = WW'(w);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      rsp_in   = rsp_ff;
      v_we     = 1'b0;
      kd_we    = 1'b0;
      v_addr   = row_ff;
      v_wdata  = vrd_ff;
      k_wdata  = krd_ff;
      d_wdata  = drd_ff;
      unique case (state_ff)
         S_CLEAR: begin
            v_we    = 1'b1;
            v_addr  = BW'(clr_ff);
            v_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (BW+1)'(BUCKETS - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (start) state_in = S_READ;
         S_READ: begin
            state_in = S_IDLE;
            rsp_in   = '{status: ST_MISS, value_out: '0};
            case (job_ff.op)
               OP_LOOKUP: if (hit) rsp_in = '{ST_OK, drd_ff[hit_w*VAL_W +: VAL_W]};
               OP_INSERT: begin
                  if (hit) rsp_in.status = ST_DUP;
                  else if (!has_free) rsp_in.status = ST_FULL;
                  else begin
                     rsp_in.status = ST_OK;
                     v_we = 1'b1; kd_we = 1'b1;
                     v_wdata[free_w] = 1'b1;
                     k_wdata[free_w*KEY_W +: KEY_W] = job_ff.key;
                     d_wdata[free_w*VAL_W +: VAL_W] = job_ff.value;
                  end
               end
               OP_DELETE: begin
                  if (hit) begin
                     rsp_in = '{ST_OK, drd_ff[hit_w*VAL_W +: VAL_W]};
                     v_we = 1'b1;
                     v_wdata[hit_w] = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (v_we) vmem[v_addr] <= v_wdata;
      if (kd_we) begin
         kmem[row_ff] <= k_wdata;
         dmem[row_ff] <= d_wdata;
      end
      vrd_ff <= vmem[bucket];
      krd_ff <= kmem[bucket];
      drd_ff <= dmem[bucket];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         done_ff  <= (state_ff == S_READ);
      end
      if (start && state_ff == S_IDLE) begin
         row_ff <= bucket;
         job_ff <= job;
      end
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff == S_CLEAR);
   assign done = done_ff;
   assign rsp  = rsp_ff;
endmodule
`default_nettype wire

// File: rtl/hashed_key_value_map_top.sv
`default_nettype none
// Path from req accept to rsp valid: multiply, add, fold mod 2^31-1,
// 32 restoring-remainder steps, row read, update, output register.
// Items: one at a time, the bit-serial bucket remainder taking the longest;
// the next req waits for the rsp handshake of the one before.
// Reset: synchronous, restores config (bucket_count 256, multiplier 31), then
// sweeps the valid memory one bucket per cycle over every row, req_ready low.
module hashed_key_value_map_top #(
   parameter int BUCKETS = 256,
   parameter int WAYS    = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire hkvm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output hkvm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [0:0]        csr_index,
   input  wire logic [31:0]       csr_data
);
   import hkvm_pkg::*;
   localparam int BW = $clog2(BUCKETS);

   logic [8:0]  bcount_ff;
   logic [31:0] mult_ff;
   logic        busy_ff;     // item in flight or result waiting
   job_type     job_ff;
   logic        hash_done, tbl_busy, tbl_done;
   logic [BW-1:0] bucket;
   rsp_type     tbl_rsp;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic        req_fire;

   assign req_ready = !busy_ff && !tbl_busy;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bcount_ff    <= 9'd256;
         mult_ff      <= 32'd31;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_BUCKET_COUNT: bcount_ff <= csr_data[8:0];
               CSR_HASH_MULT:    mult_ff   <= csr_data;
               default: ;
            endcase
         end
         if (req_fire) busy_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) busy_ff <= 1'b0;
         if (tbl_done) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (req_fire) job_ff <= '{req_data.req_type, req_data.key, req_data.value};
      if (tbl_done) rsp_ff <= tbl_rsp;
   end

   hkvm_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock, .reset, .start(req_fire), .key(req_data.key), .mult(mult_ff),
      .bucket_count(bcount_ff), .done(hash_done), .bucket(bucket)
   );

   hkvm_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_table (
      .clock, .reset, .start(hash_done), .bucket(bucket), .job(job_ff),
      .busy(tbl_busy), .done(tbl_done), .rsp(tbl_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready) else $error("req accepted while busy");
   a_done_implies_busy: assert property (@(posedge clock) disable iff (reset)
      tbl_done |-> busy_ff) else $error("table result without item");
   a_result_ok_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_DUP || rsp_data.status == ST_FULL)
      |-> rsp_data.value_out == '0) else $error("value on reject");
endmodule
`default_nettype wire

// File: dv/hashed_key_value_map_top_tb.sv
`default_nettype none
module hashed_key_value_map_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hkvm_pkg::*;

   localparam int BUCKETS = 256;
   localparam int WAYS = 4;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 60;   // margin beyond the latency of one item
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = CSR_BUCKET_COUNT;
   logic [31:0] csr_data = '0;

   always #6 clock = ~clock;

   hashed_key_value_map_top #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Mirror of the table and its config, updated as items are accepted.
   logic [8:0] map_buckets;
   logic [31:0] map_mult;
   logic slot_used [BUCKETS*WAYS];
   logic [KEY_W-1:0] slot_key [BUCKETS*WAYS];
   logic [VAL_W-1:0] slot_val [BUCKETS*WAYS];

   req_type pending_reqs[$];   // items waiting for the driver
   rsp_type expected_rsps[$];  // predicted results, oldest first

   int snd_idle_pct = 0;
   int rcv_stall_pct = 0;
   logic req_acc = 1'b0;        // item taken at the last rising edge
   int cycles = 0;
   int errors = 0;
   int n_items = 0;
   int n_status [4] = '{0, 0, 0, 0};
   logic [31:0] key_pool [24];

   function automatic int unsigned bucket_of(logic [31:0] k);
      logic [31:0] h;
      int unsigned n;
      n = map_buckets;
      if (n == 0) n = 1;           // zero acts as a single bucket
      if (n > BUCKETS) n = BUCKETS; // saturate oversized counts
      h = map_mult * k + HASH_ADD;
      h = h % HASH_PRIME;
      return h % n;
   endfunction

   // Apply one request to the mirror and return the result it must give.
   function automatic rsp_type apply_request(req_type r);
      rsp_type res;
      int base;
      int hit;
      int free_way;
      base = bucket_of(r.key) * WAYS;
      hit = -1;
      free_way = -1;
      res.status = ST_MISS;
      res.value_out = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (slot_used[base+w]) begin
            if (hit < 0 && slot_key[base+w] == r.key) hit = w;
         end else if (free_way < 0) begin
            free_way = w;
         end
      end
      case (r.req_type)
         OP_LOOKUP: begin
            if (hit >= 0) begin
               res.status = ST_OK;
               res.value_out = slot_val[base+hit];
            end
         end
         OP_INSERT: begin
            if (hit >= 0) begin
               res.status = ST_DUP;
            end else if (free_way < 0) begin
               res.status = ST_FULL;
            end else begin
               // lowest free way takes the entry
               slot_used[base+free_way] = 1'b1;
               slot_key[base+free_way] = r.key;
               slot_val[base+free_way] = r.value;
               res.status = ST_OK;
            end
         end
         OP_DELETE: begin
            if (hit >= 0) begin
               res.status = ST_OK;
               res.value_out = slot_val[base+hit];
               slot_used[base+hit] = 1'b0;
            end
         end
         default: ;  // unused opcode: miss, no change
      endcase
      return res;
   endfunction

   // Monitor: check results, predict accepted items, watch the clock budget.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_rsps.size());
         $display("Verification failed");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("unexpected result status=%0d value=%h",
                           rsp_data.status, rsp_data.value_out);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               n_status[exp_rsp.status] = n_status[exp_rsp.status] + 1;
               if (rsp_data.status !== exp_rsp.status ||
                   rsp_data.value_out !== exp_rsp.value_out) begin
                  errors = errors + 1;
                  if (errors <= 10)
                     $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                              exp_rsp.status, rsp_data.status,
                              exp_rsp.value_out, rsp_data.value_out);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.push_back(apply_request(req_data));
            n_items = n_items + 1;
         end
      end
      req_acc <= !reset && req_valid && req_ready;
   end

   // Driver: new item or idle at the falling edge once the last one is gone.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_acc) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   task automatic write_csr(logic [0:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_BUCKET_COUNT) map_buckets = data[8:0];
      else map_mult = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_req(logic [1:0] op, logic [31:0] k, logic [62:0] v);
      req_type r;
      r.req_type = op;
      r.key = k;
      r.value = v;
      pending_reqs.push_back(r);
   endtask

   // Hold off until the queue is drained and every result is back.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [62:0] rand_value();
      return 63'({$urandom(), $urandom()});
   endfunction

   initial begin
      int r;
      logic [1:0] op;
      logic [31:0] k;
      logic [8:0] bucket_cfg [6] = '{9'd256, 9'd1, 9'd2, 9'd0, 9'd511, 9'd17};
      logic [31:0] mult_cfg [6];

      map_buckets = 9'd256;
      map_mult = 32'd31;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_key[i] = '0;
         slot_val[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset config, extremes, every opcode.
      push_req(OP_LOOKUP, 32'h0, '0);
      push_req(OP_INSERT, 32'h0, {63{1'b1}});
      push_req(OP_INSERT, 32'hFFFF_FFFF, '0);
      push_req(OP_INSERT, 32'h0, 63'h5);           // duplicate
      push_req(OP_LOOKUP, 32'h0, '0);
      push_req(OP_LOOKUP, 32'hFFFF_FFFF, {63{1'b1}});
      push_req(OP_DELETE, 32'h0, '0);
      push_req(OP_DELETE, 32'h0, '0);              // already gone
      push_req(OP_UNUSED, 32'hFFFF_FFFF, {63{1'b1}});
      push_req(OP_LOOKUP, 32'h0, '0);
      drain();

      // Single bucket: fill all ways, then overflow; old entry may stay stranded.
      write_csr(CSR_BUCKET_COUNT, 32'hFFFF_FE01);  // upper bits dropped -> 1
      for (int i = 0; i < WAYS + 2; i++)
         push_req(OP_INSERT, 32'h100 + i, rand_value());
      push_req(OP_LOOKUP, 32'hFFFF_FFFF, '0);
      push_req(OP_DELETE, 32'h101, '0);
      push_req(OP_INSERT, 32'h1FF, rand_value());  // reuses the freed way
      push_req(OP_LOOKUP, 32'h1FF, '0);
      drain();

      mult_cfg = '{32'd31, 32'hFFFF_FFFF, $urandom(), $urandom(), $urandom(), 32'd0};
      for (int ph = 0; ph < 6; ph++) begin
         // random upper bits must be ignored
         write_csr(CSR_BUCKET_COUNT, {23'($urandom()), bucket_cfg[ph]});
         write_csr(CSR_HASH_MULT, mult_cfg[ph]);
         // idle mix rotates: none, sender, receiver, both
         case (ph % 4)
            0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin snd_idle_pct = 69; rcv_stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  rcv_stall_pct = 69; end
            default: begin snd_idle_pct = 32; rcv_stall_pct = 32; end
         endcase
         key_pool[0] = 32'h0;
         key_pool[1] = 32'hFFFF_FFFF;
         for (int i = 2; i < 24; i++) key_pool[i] = $urandom();
         // mostly churn on a small key pool so hits, duplicates and full buckets occur
         for (int i = 0; i < 290; i++) begin
            r = $urandom_range(99);
            if (r < 40) op = OP_INSERT;
            else if (r < 70) op = OP_LOOKUP;
            else if (r < 95) op = OP_DELETE;
            else op = OP_UNUSED;
            k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(23)] : $urandom();
            push_req(op, k, rand_value());
         end
         drain();
      end

      if (expected_rsps.size() != 0) errors = errors + expected_rsps.size();
      $display("%0d items over 8 phases, bucket counts 0..511, multipliers 0..max",
               n_items);
      $display("results: ok %0d, miss %0d, dup %0d, full %0d; %0d errors",
               n_status[0], n_status[1], n_status[2], n_status[3], errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
